>>> hdl/owsf_pkg.sv
// shared types and constants for the omni wheel speed framer
`timescale 1ns / 1ps
package owsf_pkg;

    localparam int FS_W       = 8;
    localparam int TRIM_W     = 11;
    localparam int CMD_W      = 8;
    localparam int TRIM_FRAC  = 10;
    localparam int MULT_W     = FS_W + TRIM_W;
    localparam int QUO_W      = MULT_W + 1;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAME_LEN  = 10;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND    = 2'd2;

    localparam logic [7:0] SYNC_0 = 8'hFF;
    localparam logic [7:0] SYNC_1 = 8'hFE;

    localparam logic [CNT_W-1:0] POS_SYNC_0 = 4'd0;
    localparam logic [CNT_W-1:0] POS_SYNC_1 = 4'd1;
    localparam logic [CNT_W-1:0] POS_CMD    = 4'd2;
    localparam logic [CNT_W-1:0] POS_A      = 4'd4;
    localparam logic [CNT_W-1:0] POS_B      = 4'd6;
    localparam logic [CNT_W-1:0] POS_C      = 4'd8;
    localparam logic [CNT_W-1:0] POS_DIR    = 4'd9;

    typedef struct packed {
        logic [2:0] dir;
        logic       side_zero;
        logic       max_zero;
    } t_flags;

endpackage

>>> hdl/owsf_kin.sv
// kinematics pipeline: products, wheel sums, magnitudes, maximum
`timescale 1ns / 1ps
module owsf_kin #(
    parameter int VW = 16,
    parameter int CF = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic signed [VW-1:0]           i_fwd,
    input  logic signed [VW-1:0]           i_side,
    input  logic signed [VW-1:0]           i_turn,
    output logic                           o_vld,
    output logic [VW+CF+5:0]               o_mag_a,
    output logic [VW+CF+5:0]               o_mag_b,
    output logic [VW+CF+5:0]               o_mag_c,
    output logic [VW+CF+5:0]               o_max,
    output owsf_pkg::t_flags               o_flags
);
    localparam int CW = CF + 3;
    localparam int PW = VW + CW + 1;
    localparam int WW = PW + 2;
    localparam logic [63:0] ONE     = 64'd1 << CF;
    localparam logic [63:0] K_TURN  = (64'd526 * ONE + 64'd50) / 64'd100;
    localparam logic [63:0] K_SIDE2 = (64'd2 * ONE + 64'd5) / 64'd10;
    localparam logic [63:0] K_SIDE1 = (ONE + 64'd5) / 64'd10;
    localparam logic [63:0] K_FWD   = (64'd173205 * ONE + 64'd500000) / 64'd1000000;
    localparam logic signed [PW-1:0] KT  = PW'(K_TURN[CW-1:0]);
    localparam logic signed [PW-1:0] KS2 = PW'(K_SIDE2[CW-1:0]);
    localparam logic signed [PW-1:0] KS1 = PW'(K_SIDE1[CW-1:0]);
    localparam logic signed [PW-1:0] KF  = PW'(K_FWD[CW-1:0]);

    logic                 r_vld1, r_vld2, r_vld3;
    logic signed [PW-1:0] r_p_turn, r_p_side2, r_p_side1, r_p_fwd;
    logic                 r_sz1, r_sz2, r_sz3;
    logic signed [WW-1:0] r_wa, r_wb, r_wc;
    logic [WW-1:0]        r_ma, r_mb, r_mc;
    logic [2:0]           r_dir3;
    logic [WW-1:0]        n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            o_vld  <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            o_vld  <= r_vld3;
        end
    end

    // stage 1: coefficient products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_turn  <= KT * PW'(i_turn);
            r_p_side2 <= KS2 * PW'(i_side);
            r_p_side1 <= KS1 * PW'(i_side);
            r_p_fwd   <= KF * PW'(i_fwd);
            r_sz1     <= (i_side == '0);
        end
    end

    // stage 2: wheel sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wa  <= WW'(r_p_turn) - WW'(r_p_side2);
            r_wb  <= WW'(r_p_turn) + WW'(r_p_side1) - WW'(r_p_fwd);
            r_wc  <= WW'(r_p_turn) + WW'(r_p_side1) + WW'(r_p_fwd);
            r_sz2 <= r_sz1;
        end
    end

    // stage 3: magnitudes and direction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= r_wa[WW-1] ? WW'(-r_wa) : WW'(r_wa);
            r_mb   <= r_wb[WW-1] ? WW'(-r_wb) : WW'(r_wb);
            r_mc   <= r_wc[WW-1] ? WW'(-r_wc) : WW'(r_wc);
            r_dir3 <= {r_wa[WW-1], r_wb[WW-1], r_wc[WW-1]};
            r_sz3  <= r_sz2;
        end
    end

    // stage 4: largest magnitude
    always_comb begin
        n_max = r_ma;
        if (r_mb > n_max) n_max = r_mb;
        if (r_mc > n_max) n_max = r_mc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag_a           <= r_ma;
            o_mag_b           <= r_mb;
            o_mag_c           <= r_mc;
            o_max             <= n_max;
            o_flags.dir       <= r_dir3;
            o_flags.side_zero <= r_sz3;
            o_flags.max_zero  <= (n_max == '0);
        end
    end
endmodule

>>> hdl/owsf_div.sv
// pipelined scaled ratio floor(mult*num/den), one multiplier bit per stage
`timescale 1ns / 1ps
module owsf_div #(
    parameter int MW = 40
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [owsf_pkg::MULT_W-1:0]  i_mult,
    input  logic [MW-1:0]                i_num,
    input  logic [MW-1:0]                i_den,
    output logic [owsf_pkg::QUO_W-1:0]   o_quo
);
    localparam int NS = owsf_pkg::MULT_W;
    localparam int RW = MW + 2;

    logic [NS-1:0]              r_mult [NS];
    logic [MW-1:0]              r_num  [NS];
    logic [MW-1:0]              r_den  [NS];
    logic [RW-1:0]              r_rem  [NS];
    logic [owsf_pkg::QUO_W-1:0] r_quo  [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [NS-1:0]              w_mult;
            logic [MW-1:0]              w_num, w_den;
            logic [RW-1:0]              w_rem, w_t, w_d1, w_d2;
            logic [owsf_pkg::QUO_W-1:0] w_quo;
            logic                       w_c1, w_c2;
            if (k == 0) begin : g_first
                assign w_mult = i_mult;
                assign w_num  = i_num;
                assign w_den  = i_den;
                assign w_rem  = '0;
                assign w_quo  = '0;
            end else begin : g_next
                assign w_mult = r_mult[k-1];
                assign w_num  = r_num[k-1];
                assign w_den  = r_den[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_quo  = r_quo[k-1];
            end
            // remainder stays below den, so at most two subtractions
            assign w_d1 = RW'(w_den);
            assign w_d2 = RW'(w_den) << 1;
            assign w_t  = (w_rem << 1) + (w_mult[NS-1-k] ? RW'(w_num) : '0);
            assign w_c2 = (w_t >= w_d2);
            assign w_c1 = (w_t >= w_d1);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_mult[k] <= w_mult;
                    r_num[k]  <= w_num;
                    r_den[k]  <= w_den;
                    r_rem[k]  <= w_c2 ? (w_t - w_d2) : (w_c1 ? (w_t - w_d1) : w_t);
                    r_quo[k]  <= (w_quo << 1)
                                 + (w_c2 ? 2'd2 : (w_c1 ? 2'd1 : 2'd0));
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[NS-1];
endmodule

>>> hdl/owsf_ser.sv
// code saturation and ten-word frame output register
`timescale 1ns / 1ps
module owsf_ser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [owsf_pkg::QUO_W-1:0]    i_quo_a,
    input  logic [owsf_pkg::QUO_W-1:0]    i_quo_b,
    input  logic [owsf_pkg::QUO_W-1:0]    i_quo_c,
    input  owsf_pkg::t_flags              i_flags,
    input  logic [owsf_pkg::FS_W-1:0]     i_full_scale,
    input  logic [owsf_pkg::CMD_W-1:0]    i_command,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [7:0]                    o_frame_byte,
    output logic                          o_last_byte,
    output logic                          o_take
);
    logic [owsf_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic [7:0]                 r_code_a, r_code_b, r_code_c;
    logic [2:0]                 r_dir;
    logic                       w_last;

    function automatic logic [7:0] sat_code(
        input logic [owsf_pkg::QUO_W-1:0] quo,
        input logic                       trimmed,
        input logic                       zero,
        input logic [owsf_pkg::FS_W-1:0]  fs
    );
        logic [owsf_pkg::QUO_W-1:0] c;
        c = trimmed ? (quo >> owsf_pkg::TRIM_FRAC) : quo;
        if (zero) return 8'd0;
        if (c > owsf_pkg::QUO_W'(fs)) return fs;
        return c[7:0];
    endfunction

    assign w_last = (r_cnt == owsf_pkg::POS_DIR);
    assign o_take = !r_busy || (i_ready && w_last);
    assign o_valid = r_busy;
    assign o_last_byte = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load && o_take) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy && i_ready) begin
            if (w_last) r_busy <= 1'b0;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_take) begin
            r_code_a <= sat_code(i_quo_a, 1'b0, i_flags.max_zero, i_full_scale);
            r_code_b <= sat_code(i_quo_b, !i_flags.side_zero, i_flags.max_zero,
                                 i_full_scale);
            r_code_c <= sat_code(i_quo_c, i_flags.side_zero, i_flags.max_zero,
                                 i_full_scale);
            r_dir    <= i_flags.max_zero ? 3'd0 : i_flags.dir;
        end
    end

    always_comb begin
        case (r_cnt)
            owsf_pkg::POS_SYNC_0: o_frame_byte = owsf_pkg::SYNC_0;
            owsf_pkg::POS_SYNC_1: o_frame_byte = owsf_pkg::SYNC_1;
            owsf_pkg::POS_CMD:    o_frame_byte = i_command;
            owsf_pkg::POS_A:      o_frame_byte = r_code_a;
            owsf_pkg::POS_B:      o_frame_byte = r_code_b;
            owsf_pkg::POS_C:      o_frame_byte = r_code_c;
            owsf_pkg::POS_DIR:    o_frame_byte = {5'd0, r_dir};
            default:              o_frame_byte = 8'd0;
        endcase
    end
endmodule

>>> hdl/omni_wheel_speed_framer_core.sv
// top level of the three-wheel omni speed framer
`timescale 1ns / 1ps
// channel   | handshake           | word
// ----------+---------------------+----------------------------------------------
// command   | i_valid / o_ready   | i_forward_velocity, i_sideways_velocity, i_turn_rate
// frame     | o_valid / i_ready   | o_frame_byte, o_last_byte (ten words per command)
// config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// from accept, a command passes kinematics stages, divider stages and output register
// throughput is one command per ten frame words, set by the output register
// the kinematics and divider pipeline takes a command every cycle when not stalled
// reset (synchronous, active low) clears valid bits, frame counter; config gets defaults
// with the last stage full, a frame stall freezes the pipeline; nothing lost or repeated
module omni_wheel_speed_framer_core #(
    parameter int VELOCITY_WIDTH      = 16,
    parameter int COEFF_FRACTION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [VELOCITY_WIDTH-1:0]     i_forward_velocity,
    input  logic signed [VELOCITY_WIDTH-1:0]     i_sideways_velocity,
    input  logic signed [VELOCITY_WIDTH-1:0]     i_turn_rate,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [7:0]                           o_frame_byte,
    output logic                                 o_last_byte,
    input  logic                                 i_cfg_we,
    input  logic [owsf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [owsf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    // magnitude width: velocity + coefficient (CF+3) + sign + growth
    localparam int MW = VELOCITY_WIDTH + COEFF_FRACTION_BITS + 6;
    localparam int NS = owsf_pkg::MULT_W;

    logic [owsf_pkg::FS_W-1:0]   r_full_scale;
    logic [owsf_pkg::TRIM_W-1:0] r_trim;
    logic [owsf_pkg::CMD_W-1:0]  r_command;
    logic [NS-1:0]               r_fs_trim;

    logic                        w_en, w_take;
    logic                        k_vld;
    logic [MW-1:0]               k_mag_a, k_mag_b, k_mag_c, k_max;
    owsf_pkg::t_flags            k_flags;
    logic [NS-1:0]               w_mult_plain, w_mult_b, w_mult_c;
    logic [owsf_pkg::QUO_W-1:0]  w_quo_a, w_quo_b, w_quo_c;

    // valid bits and flags ride alongside the divider stages
    logic                        r_vld   [NS];
    owsf_pkg::t_flags            r_flags [NS];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= 8'd15;
            r_trim       <= 11'd1050;
            r_command    <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                owsf_pkg::CFG_FULL_SCALE: r_full_scale <= i_cfg_data[owsf_pkg::FS_W-1:0];
                owsf_pkg::CFG_TRIM_GAIN:  r_trim       <= i_cfg_data[owsf_pkg::TRIM_W-1:0];
                owsf_pkg::CFG_COMMAND:    r_command    <= i_cfg_data[owsf_pkg::CMD_W-1:0];
                default:                  ;
            endcase
        end
    end

    // trimmed multiplier, full scale times Q1.10 gain
    always_ff @(posedge i_clk) begin
        r_fs_trim <= NS'(r_full_scale) * NS'(r_trim);
    end

    // whole pipeline advances when its last stage is empty or the framer takes it
    assign w_en    = !r_vld[NS-1] || w_take;
    assign o_ready = w_en;

    owsf_kin #(
        .VW (VELOCITY_WIDTH),
        .CF (COEFF_FRACTION_BITS)
    ) u_kin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_fwd   (i_forward_velocity),
        .i_side  (i_sideways_velocity),
        .i_turn  (i_turn_rate),
        .o_vld   (k_vld),
        .o_mag_a (k_mag_a),
        .o_mag_b (k_mag_b),
        .o_mag_c (k_mag_c),
        .o_max   (k_max),
        .o_flags (k_flags)
    );

    // trim lands on wheel c with no sideways motion, else on wheel b
    assign w_mult_plain = NS'(r_full_scale);
    assign w_mult_b     = k_flags.side_zero ? w_mult_plain : r_fs_trim;
    assign w_mult_c     = k_flags.side_zero ? r_fs_trim : w_mult_plain;

    owsf_div #(.MW(MW)) u_div_a (
        .i_clk (i_clk), .i_en (w_en), .i_mult (w_mult_plain),
        .i_num (k_mag_a), .i_den (k_max), .o_quo (w_quo_a)
    );
    owsf_div #(.MW(MW)) u_div_b (
        .i_clk (i_clk), .i_en (w_en), .i_mult (w_mult_b),
        .i_num (k_mag_b), .i_den (k_max), .o_quo (w_quo_b)
    );
    owsf_div #(.MW(MW)) u_div_c (
        .i_clk (i_clk), .i_en (w_en), .i_mult (w_mult_c),
        .i_num (k_mag_c), .i_den (k_max), .o_quo (w_quo_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= k_vld;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flags[0] <= k_flags;
            for (int k = 1; k < NS; k++) r_flags[k] <= r_flags[k-1];
        end
    end

    owsf_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_vld[NS-1]),
        .i_quo_a      (w_quo_a),
        .i_quo_b      (w_quo_b),
        .i_quo_c      (w_quo_c),
        .i_flags      (r_flags[NS-1]),
        .i_full_scale (r_full_scale),
        .i_command    (r_command),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte),
        .o_take       (w_take)
    );
endmodule

>>> bench/testbench.sv
// self-checking bench for the omni wheel speed framer: directed table, then random commands
`timescale 1ns / 1ps
module testbench;

    localparam int VW = 16;

    // index past the end of the register list, the block ignores it
    localparam logic [owsf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // wheel matrix coefficients in the block's fixed point (16 fraction bits)
    localparam longint ONE_Q   = 64'd1 << 16;
    localparam longint C_TURN  = (526 * ONE_Q + 50) / 100;
    localparam longint C_SIDE2 = (2 * ONE_Q + 5) / 10;
    localparam longint C_SIDE1 = (ONE_Q + 5) / 10;
    localparam longint C_FWD   = (173205 * ONE_Q + 500000) / 1000000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_word;

    typedef struct {
        logic signed [VW-1:0] fwd;
        logic signed [VW-1:0] side;
        logic signed [VW-1:0] turn;
        bit                   typed;
        logic [7:0]           a, b, c;
        logic [2:0]           dir;
    } t_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic signed [VW-1:0]            i_forward_velocity = '0;
    logic signed [VW-1:0]            i_sideways_velocity = '0;
    logic signed [VW-1:0]            i_turn_rate = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [7:0]                      o_frame_byte;
    logic                            o_last_byte;
    logic                            i_cfg_we = 1'b0;
    logic [owsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [owsf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    omni_wheel_speed_framer_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // own copy of the registers
    logic [owsf_pkg::FS_W-1:0]   fs_code   = 8'd15;
    logic [owsf_pkg::TRIM_W-1:0] trim_gain = 11'd1050;
    logic [owsf_pkg::CMD_W-1:0]  cmd_code  = 8'd2;

    t_frame_word pending_words[$];
    int          errors = 0;
    int          words_seen = 0;
    int          commands = 0;
    bit          calm = 1'b0;   // no idling on either side while set
    int          stall_left = 0;
    int          stall_draw = 0;

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    // speed code of one wheel, floor(scale*|w|/peak), trimmed in Q1.10, saturated
    function automatic logic [7:0] speed_code(input longint unsigned mag,
                                              input longint unsigned peak,
                                              input bit trimmed);
        longint unsigned q;
        if (peak == 0) return 8'd0;
        if (trimmed) q = (fs_code * trim_gain * mag / peak) >> owsf_pkg::TRIM_FRAC;
        else q = fs_code * mag / peak;
        if (q > fs_code) q = fs_code;
        return q[7:0];
    endfunction

    // wheel codes and direction bits for one velocity command
    task automatic wheel_codes(input logic signed [VW-1:0] fwd, side, turn,
                               output logic [7:0] a, b, c, output logic [2:0] dir);
        longint wa, wb, wc;
        longint unsigned ma, mb, mc, peak;
        wa = C_TURN * turn - C_SIDE2 * side;
        wb = C_TURN * turn + C_SIDE1 * side - C_FWD * fwd;
        wc = C_TURN * turn + C_SIDE1 * side + C_FWD * fwd;
        ma = wa < 0 ? -wa : wa;
        mb = wb < 0 ? -wb : wb;
        mc = wc < 0 ? -wc : wc;
        peak = ma;
        if (mb > peak) peak = mb;
        if (mc > peak) peak = mc;
        dir = {wa < 0, wb < 0, wc < 0};
        a = speed_code(ma, peak, 1'b0);
        b = speed_code(mb, peak, side != 0);
        c = speed_code(mc, peak, side == 0);
    endtask

    task automatic queue_frame(input logic [7:0] a, b, c, input logic [2:0] dir);
        logic [7:0] bytes[owsf_pkg::FRAME_LEN];
        bytes = '{owsf_pkg::SYNC_0, owsf_pkg::SYNC_1, cmd_code, 8'd0, a, 8'd0, b, 8'd0, c,
                  {5'd0, dir}};
        foreach (bytes[k])
            pending_words.push_back('{bytes[k], k == owsf_pkg::FRAME_LEN - 1});
    endtask

    // one command word: random gap, hold valid until accepted, then queue its frame
    task automatic send(input t_row r);
        int gap;
        logic [7:0] a, b, c;
        logic [2:0] dir;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_forward_velocity <= r.fwd;
        i_sideways_velocity <= r.side;
        i_turn_rate <= r.turn;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (r.typed) begin
            a = r.a; b = r.b; c = r.c; dir = r.dir;
        end else begin
            wheel_codes(r.fwd, r.side, r.turn, a, b, c, dir);
        end
        queue_frame(a, b, c, dir);
        commands++;
    endtask

    // wait for every frame word, then out past the pipeline depth
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // register write; the local copy follows the block's masking
    task automatic set_reg(input logic [owsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [owsf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            owsf_pkg::CFG_FULL_SCALE: fs_code = data[owsf_pkg::FS_W-1:0];
            owsf_pkg::CFG_TRIM_GAIN:  trim_gain = data[owsf_pkg::TRIM_W-1:0];
            owsf_pkg::CFG_COMMAND:    cmd_code = data[owsf_pkg::CMD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [owsf_pkg::CFG_DATA_W-1:0] fs, trim, cmd);
        set_reg(owsf_pkg::CFG_FULL_SCALE, fs);
        set_reg(owsf_pkg::CFG_TRIM_GAIN, trim);
        set_reg(owsf_pkg::CFG_COMMAND, cmd);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [VW-1:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return VW'($urandom_range(0, 40) - 20);
            3: return 16'sd0;
            default: return VW'($urandom());
        endcase
    endfunction

    // frame side: a random stall drawn after each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && i_ready) begin
            stall_draw = calm ? 0 : $urandom_range(0, 3);
            if (stall_draw == 0) begin
                i_ready <= 1'b1;
            end else begin
                stall_left <= stall_draw;
                i_ready <= 1'b0;
            end
        end else if (!i_ready) begin
            if (stall_left <= 1) i_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // frame checker against the oldest pending word
    always @(posedge i_clk) begin : p_check
        t_frame_word want;
        if (i_rst_n && o_valid && i_ready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                $display("unexpected frame word %0h at %0t", o_frame_byte, $time);
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (o_frame_byte !== want.data) report("frame byte", o_frame_byte, want.data);
                if (o_last_byte !== want.last) report("last flag", o_last_byte, want.last);
            end
        end
    end

    // directed rows: typed results where they follow at a glance at reset settings
    t_row directed[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1, 8'd0, 8'd0, 8'd0, 3'd0},            // all wheels zero
        '{16'sd0, 16'sd0, 16'sd1000, 1, 8'd15, 8'd15, 8'd15, 3'd0},     // pure turn, C trimmed
        '{16'sd0, 16'sd0, -16'sd1000, 1, 8'd15, 8'd15, 8'd15, 3'd7},    // pure turn reversed
        '{16'sh7FFF, 16'sd0, 16'sd0, 1, 8'd0, 8'd15, 8'd15, 3'd2},      // forward only
        '{16'sh8000, 16'sd0, 16'sd0, 1, 8'd0, 8'd15, 8'd15, 3'd1},      // backward only
        '{16'sd0, 16'sh7FFF, 16'sd0, 0, 0, 0, 0, 0},
        '{16'sd0, 16'sh8000, 16'sd0, 0, 0, 0, 0, 0},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0},
        '{16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0},
        '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0, 0},
        '{16'sh8000, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0},
        '{16'sd1, 16'sd0, 16'sd0, 0, 0, 0, 0, 0},
        '{-16'sd1, 16'sd1, -16'sd1, 0, 0, 0, 0, 0},
        '{16'sd300, 16'sd0, 16'sd10, 0, 0, 0, 0, 0},
        '{16'sd0, 16'sd500, 16'sd19, 0, 0, 0, 0, 0},
        '{16'sh5555, 16'shAAAA, 16'sh1234, 0, 0, 0, 0, 0}
    };

    // settings per random phase: full scale, trim, command
    logic [owsf_pkg::CFG_DATA_W-1:0] phase_cfg[6][3] = '{
        '{11'd255, 11'd2047, 11'd255},
        '{11'd1, 11'd0, 11'd0},
        '{11'd0, 11'd1024, 11'd90},
        '{11'h7FF, 11'd1023, 11'h7A5},   // too-wide values get masked
        '{11'd100, 11'd1, 11'd17},
        '{11'd15, 11'd1050, 11'd2}
    };

    initial begin
        t_row r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        calm = 1'b1;
        foreach (directed[n]) send(directed[n]);
        drain();
        calm = 1'b0;

        foreach (phase_cfg[p]) begin
            if (p == 3) set_reg(CFG_UNUSED, 11'h3FF);
            set_all(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            calm = (p == 4);
            for (int n = 0; n < 34; n++) begin
                r = '{rand_vel(), rand_vel(), rand_vel(), 0, 0, 0, 0, 0};
                if ($urandom_range(0, 3) == 0) r.side = 16'sd0;
                send(r);
                if (n == 17) drain();   // sender holds off until all frames are back
            end
            drain();
        end

        $display("%0d commands, %0d frame words over 7 register settings", commands, words_seen);
        $display("covered extreme velocities, zero wheels, zero scale and trim, masking");
        if (errors == 0 && pending_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d frame words pending", pending_words.size());
        $display("TEST FAILED");
        $finish;
    end
endmodule
